// File: design/stepper_phase_sequencer_core_assert.svh
// Assertion macros for the stepper phase sequencer checker.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef STEPPER_PHASE_SEQUENCER_CORE_ASSERT_SVH
`define STEPPER_PHASE_SEQUENCER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define SPS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sps checker: same-cycle property failed");

// Next-cycle implication, disabled during reset
`define SPS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sps checker: next-cycle property failed");

`endif

// File: design/sps_pkg.sv
// Shared codes, coil tables and helper arithmetic for the stepper phase sequencer.
// No dependencies; imported by the top level.
`default_nettype none

package sps_pkg;

    // Input operation codes
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_MOVE = 1'b1;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] REG_STEPS_PER_REV = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_DELAY    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COIL_MODE     = 2'd2;

    // Coil wiring modes
    localparam logic [1:0] MODE_TWO_WIRE  = 2'd0;
    localparam logic [1:0] MODE_FOUR_WIRE = 2'd1;
    localparam logic [1:0] MODE_FIVE_WIRE = 2'd2;

    // Reset values of the configuration registers
    localparam logic [15:0] SPR_RESET   = 16'd200;
    localparam logic [31:0] DELAY_RESET = 32'd0;
    localparam logic [1:0]  MODE_RESET  = MODE_FOUR_WIRE;

    localparam int unsigned COIL_W = 5;
    localparam logic [3:0]  PHASE10_LAST = 4'd9;

    typedef logic [COIL_W-1:0] coil_t;

    // Two-wire coil pattern by position mod 4
    function automatic coil_t two_wire_coils(input logic [1:0] idx);
        coil_t c;
        unique case (idx)
            2'd0: c = 5'd2;
            2'd1: c = 5'd3;
            2'd2: c = 5'd1;
            2'd3: c = 5'd0;
        endcase
        return c;
    endfunction

    // Four-wire coil pattern by position mod 4
    function automatic coil_t four_wire_coils(input logic [1:0] idx);
        coil_t c;
        unique case (idx)
            2'd0: c = 5'd5;
            2'd1: c = 5'd6;
            2'd2: c = 5'd10;
            2'd3: c = 5'd9;
        endcase
        return c;
    endfunction

    // Five-wire coil pattern by position mod 10
    function automatic coil_t five_wire_coils(input logic [3:0] idx);
        coil_t c;
        unique case (idx)
            4'd0:    c = 5'd22;
            4'd1:    c = 5'd18;
            4'd2:    c = 5'd26;
            4'd3:    c = 5'd10;
            4'd4:    c = 5'd11;
            4'd5:    c = 5'd9;
            4'd6:    c = 5'd13;
            4'd7:    c = 5'd5;
            4'd8:    c = 5'd21;
            4'd9:    c = 5'd20;
            default: c = 5'd0;
        endcase
        return c;
    endfunction

    // Remainder by ten of a 16-bit value: reciprocal multiply, then subtract
    function automatic logic [3:0] mod10_u16(input logic [15:0] x);
        logic [32:0] prod;
        logic [13:0] quot;
        logic [16:0] quot_x10;
        logic [15:0] rem;
        prod     = {17'd0, x} * 33'd52429;
        quot     = prod[32:19];
        quot_x10 = {quot, 3'b000} + {2'b00, quot, 1'b0};
        rem      = x - quot_x10[15:0];
        return rem[3:0];
    endfunction

endpackage

`default_nettype wire

// File: design/stepper_phase_sequencer_core.sv
// Stepper phase sequencer: ticks and move commands in, coil levels and position out.
// Each input beat passes through the input register, then the result register; the state
// update is one pass of adder/compare logic. Throughput: one beat per cycle without stalls.
// Reset: asynchronous, active low; clears position, direction, step count, elapsed
// count and coils, and loads 200 steps per revolution, zero delay and four-wire mode.
// Depends on sps_pkg.
`default_nettype none

module stepper_phase_sequencer_core (
    input  wire                             clk,
    input  wire                             rst_n,
    // configuration write port
    input  wire                             cfg_we,
    input  wire [sps_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire [sps_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // input channel
    input  wire                             in_valid,
    output logic                            in_stall,
    input  wire                             op,
    input  wire signed [15:0]               move_steps,
    // result channel
    output logic                            out_valid,
    input  wire                             out_stall,
    output sps_pkg::coil_t                  coils,
    output logic                            stepped,
    output logic [15:0]                     steps_remaining,
    output logic [15:0]                     position
);
    import sps_pkg::*;

    // configuration
    logic [15:0] spr_reg;
    logic [31:0] delay_reg;
    logic [1:0]  mode_reg;
    logic [3:0]  wrap10_reg;     // (effective steps_per_rev - 1) mod 10
    logic [15:0] cfg_spr_eff;
    logic [15:0] cfg_wrap_pos;

    // input stage
    logic        s1_valid_reg;
    logic        s1_op_reg;
    logic [15:0] s1_move_reg;
    logic        s1_load;
    logic        advance;

    // sequencer state, which also forms the result register
    logic [15:0] pos_reg, pos_next;
    logic [3:0]  phase10_reg, phase10_next;
    logic        fwd_reg, fwd_next;
    logic [15:0] rem_reg, rem_next;
    logic [31:0] elapsed_reg, elapsed_next;
    coil_t       coil_reg, coil_next;
    logic        stepped_reg, stepped_next;
    logic        out_valid_reg;

    // step datapath
    logic [15:0] spr_eff;
    logic [31:0] elapsed_inc;
    logic        do_step;
    logic [16:0] pos_plus;
    logic        wrap_fwd;
    logic        wrap_rev;
    logic [15:0] step_pos;
    logic [3:0]  step_phase10;

    // Hold the configuration; precompute the reverse-wrap phase on write
    assign cfg_spr_eff  = (cfg_wdata[15:0] == 16'd0) ? 16'd1 : cfg_wdata[15:0];
    assign cfg_wrap_pos = cfg_spr_eff - 16'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spr_reg    <= SPR_RESET;
            delay_reg  <= DELAY_RESET;
            mode_reg   <= MODE_RESET;
            wrap10_reg <= mod10_u16(SPR_RESET - 16'd1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_STEPS_PER_REV:
                begin
                    spr_reg    <= cfg_wdata[15:0];
                    wrap10_reg <= mod10_u16(cfg_wrap_pos);
                end
                REG_STEP_DELAY: delay_reg <= cfg_wdata;
                REG_COIL_MODE:  mode_reg  <= cfg_wdata[1:0];
                default:        ;
            endcase
        end
    end

    // Move a beat from the input register to the result register when the slot frees
    assign advance  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !advance;
    assign s1_load  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_load)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_op_reg   <= op;
            s1_move_reg <= move_steps;
        end
    end

    // Decide whether a tick takes a step
    assign spr_eff     = (spr_reg == 16'd0) ? 16'd1 : spr_reg;
    assign elapsed_inc = (elapsed_reg == 32'hFFFF_FFFF) ? elapsed_reg : elapsed_reg + 32'd1;
    assign do_step     = (rem_reg != 16'd0) && (elapsed_inc >= delay_reg);

    // Next position and its phase mod 10, wrapping within the revolution
    assign pos_plus = {1'b0, pos_reg} + 17'd1;
    assign wrap_fwd = pos_plus >= {1'b0, spr_eff};
    assign wrap_rev = (pos_reg == 16'd0) || (pos_reg >= spr_eff);

    always_comb
    begin
        if (fwd_reg)
        begin
            step_pos     = wrap_fwd ? 16'd0 : pos_plus[15:0];
            step_phase10 = (wrap_fwd || phase10_reg == PHASE10_LAST) ? 4'd0
                                                                     : phase10_reg + 4'd1;
        end
        else
        begin
            step_pos     = wrap_rev ? spr_eff - 16'd1 : pos_reg - 16'd1;
            step_phase10 = wrap_rev ? wrap10_reg
                         : ((phase10_reg == 4'd0) ? PHASE10_LAST : phase10_reg - 4'd1);
        end
    end

    // Work out the next state for the beat in the input register
    always_comb
    begin
        pos_next     = pos_reg;
        phase10_next = phase10_reg;
        fwd_next     = fwd_reg;
        rem_next     = rem_reg;
        elapsed_next = elapsed_reg;
        coil_next    = coil_reg;
        stepped_next = 1'b0;
        if (s1_op_reg == OP_MOVE)
        begin
            if (s1_move_reg[15])
            begin
                rem_next = 16'd0 - s1_move_reg;
                fwd_next = 1'b0;
            end
            else
            begin
                rem_next = s1_move_reg;
                if (s1_move_reg != 16'd0)
                begin
                    fwd_next = 1'b1;
                end
            end
        end
        else if (do_step)
        begin
            pos_next     = step_pos;
            phase10_next = step_phase10;
            rem_next     = rem_reg - 16'd1;
            elapsed_next = 32'd0;
            stepped_next = 1'b1;
            unique case (mode_reg)
                MODE_TWO_WIRE:  coil_next = two_wire_coils(step_pos[1:0]);
                MODE_FOUR_WIRE: coil_next = four_wire_coils(step_pos[1:0]);
                MODE_FIVE_WIRE: coil_next = five_wire_coils(step_phase10);
                default:        coil_next = coil_reg;
            endcase
        end
        else
        begin
            elapsed_next = elapsed_inc;
        end
    end

    // Commit state and the result beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= 16'd0;
            phase10_reg   <= 4'd0;
            fwd_reg       <= 1'b0;
            rem_reg       <= 16'd0;
            elapsed_reg   <= 32'd0;
            coil_reg      <= '0;
            stepped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            pos_reg       <= pos_next;
            phase10_reg   <= phase10_next;
            fwd_reg       <= fwd_next;
            rem_reg       <= rem_next;
            elapsed_reg   <= elapsed_next;
            coil_reg      <= coil_next;
            stepped_reg   <= stepped_next;
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid       = out_valid_reg;
    assign coils           = coil_reg;
    assign stepped         = stepped_reg;
    assign steps_remaining = rem_reg;
    assign position        = pos_reg;

endmodule

`default_nettype wire

// File: design/sps_checker.sv
// Port-level checker for the stepper phase sequencer, bound to the top level.
// Depends on stepper_phase_sequencer_core_assert.svh.
`default_nettype none

`include "stepper_phase_sequencer_core_assert.svh"

module sps_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        in_valid,
    input wire        in_stall,
    input wire        out_valid,
    input wire        out_stall,
    input wire [4:0]  coils,
    input wire        stepped,
    input wire [15:0] steps_remaining,
    input wire [15:0] position
);

    // Whole result payload, for the stability check
    logic [37:0] result_bits;
    assign result_bits = {coils, stepped, steps_remaining, position};

    // A stalled result beat stays offered
    `SPS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

    // A stalled result beat keeps its payload
    `SPS_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(result_bits))

    // A fresh result follows an input beat that was accepted into the input register
    `SPS_ASSERT_NOW(a_out_origin, $rose(out_valid), $past(in_valid && !in_stall, 2))

    // After a step the count left cannot exceed the largest move minus one
    `SPS_ASSERT_NOW(a_step_count, out_valid && stepped, steps_remaining < 16'h8000)

endmodule

bind stepper_phase_sequencer_core sps_checker u_sps_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .coils           (coils),
    .stepped         (stepped),
    .steps_remaining (steps_remaining),
    .position        (position)
);

`default_nettype wire

// File: sim/tb.sv
// Self-checking testbench for stepper_phase_sequencer_core: ticks and move commands
// are driven with random gaps and checked against an in-bench prediction of coils,
// step flag, remaining count and position. Depends on sps_pkg and the core RTL.
`default_nettype none

module tb;
    import sps_pkg::*;

    // Coil patterns packed 5 bits per phase, phase 0 in the low bits
    localparam logic [19:0] TWO_WIRE_TAB  = {5'd0, 5'd1, 5'd3, 5'd2};
    localparam logic [19:0] FOUR_WIRE_TAB = {5'd9, 5'd10, 5'd6, 5'd5};
    localparam logic [49:0] FIVE_WIRE_TAB = {5'd20, 5'd21, 5'd5, 5'd13, 5'd9,
                                             5'd11, 5'd10, 5'd26, 5'd18, 5'd22};
    localparam logic [1:0]           MODE_HOLD = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        coil_t       coils;
        logic        stepped;
        logic [15:0] remaining;
        logic [15:0] position;
    } motion_t;

    // Track motor state and queue the expected result of every accepted beat
    class motion_scoreboard;
        logic [15:0] spr;
        logic [31:0] delay;
        logic [1:0]  mode;
        logic [15:0] pos;
        logic        fwd;
        logic [15:0] left;
        logic [31:0] elapsed;
        coil_t       coil_q;
        motion_t     expected_motion[$];
        int unsigned errors;
        int unsigned checked;
        int unsigned steps_taken;

        function new();
            spr         = SPR_RESET;
            delay       = DELAY_RESET;
            mode        = MODE_RESET;
            pos         = '0;
            fwd         = 1'b0;
            left        = '0;
            elapsed     = '0;
            coil_q      = '0;
            errors      = 0;
            checked     = 0;
            steps_taken = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
            case (idx)
                REG_STEPS_PER_REV: spr = data[15:0];
                REG_STEP_DELAY:    delay = data;
                REG_COIL_MODE:     mode = data[1:0];
                default: ;
            endcase
        endfunction

        function int unsigned pending();
            return expected_motion.size();
        endfunction

        // Look up the coil levels for the current position; reserved mode holds them
        function coil_t phase_coils();
            int unsigned p;
            p = pos;
            case (mode)
                MODE_TWO_WIRE:  return TWO_WIRE_TAB[(p % 4) * 5 +: 5];
                MODE_FOUR_WIRE: return FOUR_WIRE_TAB[(p % 4) * 5 +: 5];
                MODE_FIVE_WIRE: return FIVE_WIRE_TAB[(p % 10) * 5 +: 5];
                default:        return coil_q;
            endcase
        endfunction

        // Move one place; zero steps per revolution acts as one
        function void advance();
            logic [16:0] wrap;
            logic [16:0] nxt;
            wrap = (spr == 16'd0) ? 17'd1 : {1'b0, spr};
            if (fwd)
            begin
                nxt = {1'b0, pos} + 17'd1;
                pos = (nxt >= wrap) ? 16'd0 : nxt[15:0];
            end
            else if (pos == 16'd0 || {1'b0, pos} >= wrap)
            begin
                nxt = wrap - 17'd1;
                pos = nxt[15:0];
            end
            else
            begin
                pos = pos - 16'd1;
            end
        endfunction

        function void predict_item(logic op_bit, logic [15:0] raw);
            logic        did_step;
            logic [16:0] mag;
            motion_t     want;
            did_step = 1'b0;
            if (op_bit == OP_MOVE)
            begin
                // Load the magnitude; zero keeps the direction
                if (raw[15])
                begin
                    mag  = 17'h10000 - {1'b0, raw};
                    left = mag[15:0];
                    fwd  = 1'b0;
                end
                else
                begin
                    left = raw;
                    if (raw != 16'd0)
                        fwd = 1'b1;
                end
            end
            else
            begin
                if (elapsed != 32'hFFFF_FFFF)
                    elapsed = elapsed + 32'd1;
                if (left != 16'd0 && elapsed >= delay)
                begin
                    advance();
                    left     = left - 16'd1;
                    coil_q   = phase_coils();
                    elapsed  = '0;
                    did_step = 1'b1;
                    steps_taken++;
                end
            end
            want.coils     = coil_q;
            want.stepped   = did_step;
            want.remaining = left;
            want.position  = pos;
            expected_motion.push_back(want);
        endfunction

        function void check_beat(motion_t got);
            motion_t want;
            checked++;
            if (expected_motion.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("%0t: extra beat coils=%0d stepped=%0d rem=%0d pos=%0d",
                             $time, got.coils, got.stepped, got.remaining, got.position);
                return;
            end
            want = expected_motion.pop_front();
            if (got.coils !== want.coils || got.stepped !== want.stepped ||
                got.remaining !== want.remaining || got.position !== want.position)
            begin
                errors++;
                if (errors <= 10)
                    $display("%0t: exp/got coils %0d/%0d stp %0d/%0d rem %0d/%0d pos %0d/%0d",
                             $time, want.coils, got.coils, want.stepped, got.stepped,
                             want.remaining, got.remaining, want.position, got.position);
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  in_valid;
    logic                  in_stall;
    logic                  op;
    logic signed [15:0]    move_steps;
    logic                  out_valid;
    logic                  out_stall;
    coil_t                 coils;
    logic                  stepped;
    logic [15:0]           steps_remaining;
    logic [15:0]           position;

    logic                  no_idle = 1'b0;
    motion_scoreboard      sb = new();
    int unsigned           items_sent = 0;
    int unsigned           moves_sent = 0;
    int unsigned           reg_writes = 0;

    stepper_phase_sequencer_core dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .op              (op),
        .move_steps      (move_steps),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .coils           (coils),
        .stepped         (stepped),
        .steps_remaining (steps_remaining),
        .position        (position)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Bound the run
    initial
    begin
        #4000000;
        $display("FAILURE");
        $finish;
    end

    // Draw a stall before each result beat, then take it and check it
    initial
    begin
        int unsigned hold;
        motion_t     got;
        out_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            hold = no_idle ? 0 : $urandom_range(0, 10);
            repeat (hold)
            begin
                @(negedge clk);
                out_stall <= 1'b1;
            end
            @(negedge clk);
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
            got.coils     = coils;
            got.stepped   = stepped;
            got.remaining = steps_remaining;
            got.position  = position;
            sb.check_beat(got);
        end
    end

    task automatic send_beat(input logic op_bit, input logic [15:0] raw);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 10);
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid   <= 1'b1;
        op         <= op_bit;
        move_steps <= raw;
        do
            @(posedge clk);
        while (in_stall);
        sb.predict_item(op_bit, raw);
        items_sent++;
        if (op_bit == OP_MOVE)
            moves_sent++;
    endtask

    // Drop valid and hold until every expected result has come back
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        sb.write_reg(idx, data);
        reg_writes++;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Mostly ticks; moves are short runs either way, some full-range, some zero
    task automatic random_beat();
        int unsigned pick;
        logic [15:0] raw;
        pick = $urandom_range(0, 15);
        raw  = 16'($urandom_range(0, 65535));
        case (pick)
            0:       send_beat(OP_MOVE, raw);
            1:       send_beat(OP_MOVE, 16'($urandom_range(1, 40)));
            2:       send_beat(OP_MOVE, 16'd0 - 16'($urandom_range(1, 40)));
            3:       send_beat(OP_MOVE, 16'd0);
            default: send_beat(OP_TICK, raw);
        endcase
    endtask

    initial
    begin
        int unsigned count;
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_wdata  = '0;
        in_valid   = 1'b0;
        op         = OP_TICK;
        move_steps = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: idle tick, most negative count, largest forward, zero count
        send_beat(OP_TICK, 16'h0000);
        send_beat(OP_MOVE, 16'h8000);
        send_beat(OP_TICK, 16'hFFFF);
        send_beat(OP_MOVE, 16'h7FFF);
        send_beat(OP_TICK, 16'h0000);
        send_beat(OP_MOVE, 16'h0000);
        send_beat(OP_TICK, 16'h0000);

        // One step per revolution pins the position at zero; upper data bits ignored
        drain();
        set_reg(REG_STEPS_PER_REV, 32'hABCD_0001);
        send_beat(OP_MOVE, 16'd1);
        send_beat(OP_TICK, 16'd0);

        // Reverse from zero at the widest revolution
        drain();
        set_reg(REG_STEPS_PER_REV, 32'd65535);
        send_beat(OP_MOVE, 16'hFFFF);
        send_beat(OP_TICK, 16'd0);

        // Shrink the revolution under the position, then step forward
        drain();
        set_reg(REG_STEPS_PER_REV, 32'd100);
        set_reg(REG_COIL_MODE, {30'd0, MODE_FIVE_WIRE});
        send_beat(OP_MOVE, 16'd1);
        send_beat(OP_TICK, 16'd0);

        // Same, stepping in reverse
        drain();
        set_reg(REG_STEPS_PER_REV, 32'd65535);
        send_beat(OP_MOVE, 16'hFFFF);
        send_beat(OP_TICK, 16'd0);
        drain();
        set_reg(REG_STEPS_PER_REV, 32'd100);
        send_beat(OP_MOVE, 16'hFFFF);
        send_beat(OP_TICK, 16'd0);

        // Zero steps per revolution with the reserved coil mode; spare index ignored
        drain();
        set_reg(REG_STEPS_PER_REV, 32'd0);
        set_reg(REG_COIL_MODE, {30'd0, MODE_HOLD});
        set_reg(REG_SPARE, 32'hFFFF_FFFF);
        send_beat(OP_MOVE, 16'd2);
        send_beat(OP_TICK, 16'd0);
        send_beat(OP_TICK, 16'd0);

        // Two-wire coils with a step delay of three ticks
        drain();
        set_reg(REG_STEPS_PER_REV, 32'd200);
        set_reg(REG_COIL_MODE, {30'd0, MODE_TWO_WIRE});
        set_reg(REG_STEP_DELAY, 32'd3);
        send_beat(OP_MOVE, 16'd3);
        repeat (4) send_beat(OP_TICK, 16'd0);

        // Random phases, each under its own settings
        for (int ph = 0; ph < 6; ph++)
        begin
            drain();
            count = 140;
            case (ph)
                0:
                begin
                    no_idle = 1'b0;
                    set_reg(REG_STEPS_PER_REV, 32'd4);
                    set_reg(REG_STEP_DELAY, 32'd0);
                    set_reg(REG_COIL_MODE, {30'd0, MODE_TWO_WIRE});
                end
                1:
                begin
                    no_idle = 1'b1;
                    set_reg(REG_STEPS_PER_REV, 32'd10);
                    set_reg(REG_STEP_DELAY, 32'd1);
                    set_reg(REG_COIL_MODE, {30'd0, MODE_FIVE_WIRE});
                end
                2:
                begin
                    no_idle = 1'b0;
                    set_reg(REG_STEPS_PER_REV, 32'd65535);
                    set_reg(REG_STEP_DELAY, 32'd2);
                    set_reg(REG_COIL_MODE, {30'd0, MODE_FOUR_WIRE});
                end
                3:
                begin
                    no_idle = 1'b0;
                    set_reg(REG_STEPS_PER_REV, 32'd1);
                    set_reg(REG_STEP_DELAY, 32'd0);
                    set_reg(REG_COIL_MODE, {30'd0, MODE_HOLD});
                end
                4:
                begin
                    no_idle = 1'b1;
                    set_reg(REG_STEPS_PER_REV, $urandom_range(1, 60));
                    set_reg(REG_STEP_DELAY, $urandom_range(0, 4));
                    set_reg(REG_COIL_MODE, $urandom_range(0, 2));
                end
                default:
                begin
                    no_idle = 1'b0;
                    count = 50;
                    set_reg(REG_STEPS_PER_REV, 32'd37);
                    set_reg(REG_STEP_DELAY, 32'hFFFF_FFFF);
                    set_reg(REG_COIL_MODE, {30'd0, MODE_FIVE_WIRE});
                end
            endcase
            for (int i = 0; i < count; i++)
            begin
                // Hold off the sender mid-phase until the pipe is empty
                if (ph == 2 && i == 70)
                    drain();
                random_beat();
            end
        end

        drain();
        repeat (8) @(posedge clk);
        $display("Covered %0d beats (%0d move commands) over %0d register writes,",
                 items_sent, moves_sent, reg_writes);
        $display("%0d results checked, %0d steps taken, %0d mismatches.",
                 sb.checked, sb.steps_taken, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire

// File: sim.f
+incdir+design
design/sps_pkg.sv
design/stepper_phase_sequencer_core.sv
design/sps_checker.sv
sim/tb.sv
